/* sv/three_axis_rate_pid_core_macros.svh */
// assertion macros for the three-axis rate pid core
`ifndef THREE_AXIS_RATE_PID_CORE_MACROS_SVH
`define THREE_AXIS_RATE_PID_CORE_MACROS_SVH

// concurrent check, sampled on clk, off while rstn is low
`define TRPID_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define TRPID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/trpid_pkg.sv */
// shared types and constants for the three-axis rate pid core
package trpid_pkg;

    localparam int RATE_W  = 24;
    localparam int GAIN_W  = 32;
    localparam int STEP_W  = 24;
    localparam int TQ_W    = 32;
    localparam int INTEG_W = 40;
    localparam int MA_W    = 41;
    localparam int MB_W    = 32;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int RES_W   = 64;
    localparam int DERIV_W = 42;
    localparam int CNT_W   = 5;

    localparam logic signed [DERIV_W-1:0] INTEG_MAX = DERIV_W'(64'sd549755813887);
    localparam logic signed [DERIV_W-1:0] INTEG_MIN = DERIV_W'(-64'sd549755813888);
    localparam logic signed [RES_W-1:0]   TQ_MAX    = RES_W'(64'sd2147483647);
    localparam logic signed [RES_W-1:0]   TQ_MIN    = RES_W'(-64'sd2147483648);

    typedef enum logic [1:0] {
        SH_8  = 2'd0,
        SH_16 = 2'd1,
        SH_24 = 2'd2
    } shift_t;

    typedef enum logic [2:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_TSTEP = 3'd3,
        REG_RSTEP = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic             start;
        logic [MA_W-1:0]  a;
        logic [MB_W-1:0]  b;
        logic             neg;
        shift_t           sh;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] result;
    } mul_rsp_t;

endpackage

/* sv/trpid_mul.sv */
// bit-serial sign-magnitude multiplier with rounded right shift
module trpid_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  trpid_pkg::mul_req_t  req,
    output trpid_pkg::mul_rsp_t  rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_RUN  = 4'b0010,
        M_RND  = 4'b0100,
        M_FIN  = 4'b1000
    } mstate_t;

    mstate_t                              state_reg;
    logic [trpid_pkg::MA_W-1:0]           a_reg;
    logic [trpid_pkg::PROD_W-1:0]         p_reg;
    logic [trpid_pkg::RES_W-1:0]          mag_reg;
    logic                                 neg_reg;
    trpid_pkg::shift_t                    sh_reg;
    logic [trpid_pkg::CNT_W-1:0]          cnt_reg;

    logic [trpid_pkg::MA_W-1:0]           addend;
    logic [trpid_pkg::MA_W:0]             psum;
    logic [trpid_pkg::PROD_W-1:0]         half;
    logic [trpid_pkg::PROD_W-1:0]         rounded;

    assign addend = p_reg[0] ? a_reg : '0;
    assign psum   = {1'b0, p_reg[trpid_pkg::PROD_W-1:trpid_pkg::MB_W]} + {1'b0, addend};

    always_comb begin
        case (sh_reg)
            trpid_pkg::SH_8: begin
                half    = trpid_pkg::PROD_W'(1) << 7;
                rounded = (p_reg + half) >> 8;
            end
            trpid_pkg::SH_16: begin
                half    = trpid_pkg::PROD_W'(1) << 15;
                rounded = (p_reg + half) >> 16;
            end
            trpid_pkg::SH_24: begin
                half    = trpid_pkg::PROD_W'(1) << 23;
                rounded = (p_reg + half) >> 24;
            end
            default: begin
                half    = '0;
                rounded = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.a;
                        p_reg     <= {{trpid_pkg::MA_W{1'b0}}, req.b};
                        neg_reg   <= req.neg;
                        sh_reg    <= req.sh;
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN: begin
                    p_reg   <= {psum, p_reg[trpid_pkg::MB_W-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == trpid_pkg::CNT_W'(trpid_pkg::MB_W - 1)) begin
                        state_reg <= M_RND;
                    end
                end
                M_RND: begin
                    mag_reg   <= rounded[trpid_pkg::RES_W-1:0];
                    state_reg <= M_FIN;
                end
                M_FIN: begin
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = (state_reg == M_FIN);
    assign rsp.result = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

/* sv/three_axis_rate_pid_core.sv */
// top level of the three-axis rate pid core
// One beat of three angular rates yields one beat of three damping torques. Each axis runs
// five products (derivative, integral increment and the three gain terms) through one
// bit-serial multiplier, clamping the integral after the increment and the torque after the
// three gain terms; the next beat is taken only after all three axes are done, since that
// multiplier is shared.
// One item is worked at a time; a finished result waits in the output register while the
// next beat is accepted. Integral and previous rate clear at reset.
module three_axis_rate_pid_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // rate_x, rate_y, rate_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // torque_x, torque_y, torque_z
    output logic        m_tuser,   // clipped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_INT   = 6'b001000,
        ST_TQ    = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        OP_DER = 3'd0,
        OP_INC = 3'd1,
        OP_KP  = 3'd2,
        OP_KD  = 3'd3,
        OP_KI  = 3'd4
    } op_t;

    localparam int RW = trpid_pkg::RATE_W;
    localparam int GW = trpid_pkg::GAIN_W;
    localparam int SW = trpid_pkg::STEP_W;
    localparam int TW = trpid_pkg::TQ_W;
    localparam int IW = trpid_pkg::INTEG_W;
    localparam int DW = trpid_pkg::DERIV_W;
    localparam int XW = trpid_pkg::RES_W;

    state_t                state_reg;
    op_t                   op_reg;
    logic [1:0]            axis_reg;
    logic signed [GW-1:0]  kp_reg, ki_reg, kd_reg;
    logic [SW-1:0]         tstep_reg, rstep_reg;
    logic signed [RW-1:0]  rate_reg  [3];
    logic signed [RW-1:0]  prev_reg  [3];
    logic signed [IW-1:0]  integ_reg [3];
    logic signed [TW-1:0]  tq_reg    [3];
    logic signed [DW-1:0]  deriv_reg;
    logic signed [DW-1:0]  inc_reg;
    logic signed [XW-1:0]  sum_reg;
    logic                  hit_reg;
    logic                  m_valid_reg;
    logic [95:0]           m_data_reg;
    logic                  m_user_reg;

    trpid_pkg::mul_req_t   mreq;
    trpid_pkg::mul_rsp_t   mrsp;

    logic signed [RW-1:0]  r_cur;
    logic signed [RW:0]    d_cur;
    logic [RW:0]           d_mag;
    logic [RW-1:0]         r_mag;
    logic [GW-1:0]         kp_mag, ki_mag, kd_mag;
    logic [DW-1:0]         deriv_mag;
    logic [IW-1:0]         integ_mag;
    logic signed [DW-1:0]  isum;
    logic signed [XW-1:0]  tneg;
    logic                  wr_en;
    logic                  s_acc;

    assign r_cur     = rate_reg[axis_reg];
    assign d_cur     = {r_cur[RW-1], r_cur} - {prev_reg[axis_reg][RW-1], prev_reg[axis_reg]};
    assign d_mag     = d_cur[RW] ? (RW+1)'(-d_cur) : d_cur;
    assign r_mag     = r_cur[RW-1] ? RW'(-r_cur) : r_cur;
    assign kp_mag    = kp_reg[GW-1] ? GW'(-kp_reg) : kp_reg;
    assign ki_mag    = ki_reg[GW-1] ? GW'(-ki_reg) : ki_reg;
    assign kd_mag    = kd_reg[GW-1] ? GW'(-kd_reg) : kd_reg;
    assign deriv_mag = deriv_reg[DW-1] ? DW'(-deriv_reg) : deriv_reg;
    assign integ_mag = integ_reg[axis_reg][IW-1] ? IW'(-integ_reg[axis_reg])
                                                 : integ_reg[axis_reg];
    assign isum      = DW'(integ_reg[axis_reg]) + inc_reg;
    assign tneg      = -sum_reg;

    always_comb begin
        mreq.start = (state_reg == ST_ISSUE);
        case (op_reg)
            OP_DER: begin
                mreq.a   = trpid_pkg::MA_W'(d_mag);
                mreq.b   = trpid_pkg::MB_W'(rstep_reg);
                mreq.neg = d_cur[RW];
                mreq.sh  = trpid_pkg::SH_8;
            end
            OP_INC: begin
                mreq.a   = trpid_pkg::MA_W'(r_mag);
                mreq.b   = trpid_pkg::MB_W'(tstep_reg);
                mreq.neg = r_cur[RW-1];
                mreq.sh  = trpid_pkg::SH_16;
            end
            OP_KP: begin
                mreq.a   = trpid_pkg::MA_W'(r_mag);
                mreq.b   = kp_mag;
                mreq.neg = r_cur[RW-1] ^ kp_reg[GW-1];
                mreq.sh  = trpid_pkg::SH_16;
            end
            OP_KD: begin
                mreq.a   = deriv_mag[trpid_pkg::MA_W-1:0];
                mreq.b   = kd_mag;
                mreq.neg = deriv_reg[DW-1] ^ kd_reg[GW-1];
                mreq.sh  = trpid_pkg::SH_16;
            end
            OP_KI: begin
                mreq.a   = trpid_pkg::MA_W'(integ_mag);
                mreq.b   = ki_mag;
                mreq.neg = integ_reg[axis_reg][IW-1] ^ ki_reg[GW-1];
                mreq.sh  = trpid_pkg::SH_24;
            end
            default: begin
                mreq.a   = '0;
                mreq.b   = '0;
                mreq.neg = 1'b0;
                mreq.sh  = trpid_pkg::SH_8;
            end
        endcase
    end

    trpid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign wr_en = psel && penable && pwrite;
    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            tstep_reg <= SW'(167772);
            rstep_reg <= SW'(25600);
        end else if (wr_en) begin
            case (trpid_pkg::reg_idx_t'(paddr[4:2]))
                trpid_pkg::REG_KP:    kp_reg    <= pwdata;
                trpid_pkg::REG_KI:    ki_reg    <= pwdata;
                trpid_pkg::REG_KD:    kd_reg    <= pwdata;
                trpid_pkg::REG_TSTEP: tstep_reg <= pwdata[SW-1:0];
                trpid_pkg::REG_RSTEP: rstep_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (trpid_pkg::reg_idx_t'(paddr[4:2]))
            trpid_pkg::REG_KP:    prdata = kp_reg;
            trpid_pkg::REG_KI:    prdata = ki_reg;
            trpid_pkg::REG_KD:    prdata = kd_reg;
            trpid_pkg::REG_TSTEP: prdata = 32'(tstep_reg);
            trpid_pkg::REG_RSTEP: prdata = 32'(rstep_reg);
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DER;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        rate_reg[0] <= s_tdata[23:0];
                        rate_reg[1] <= s_tdata[47:24];
                        rate_reg[2] <= s_tdata[71:48];
                        axis_reg    <= '0;
                        op_reg      <= OP_DER;
                        hit_reg     <= 1'b0;
                        state_reg   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mrsp.done) begin
                        case (op_reg)
                            OP_DER: begin
                                deriv_reg <= mrsp.result[DW-1:0];
                                op_reg    <= OP_INC;
                                state_reg <= ST_ISSUE;
                            end
                            OP_INC: begin
                                inc_reg   <= mrsp.result[DW-1:0];
                                state_reg <= ST_INT;
                            end
                            OP_KP: begin
                                sum_reg   <= mrsp.result;
                                op_reg    <= OP_KD;
                                state_reg <= ST_ISSUE;
                            end
                            OP_KD: begin
                                sum_reg   <= sum_reg + mrsp.result;
                                op_reg    <= OP_KI;
                                state_reg <= ST_ISSUE;
                            end
                            OP_KI: begin
                                sum_reg   <= sum_reg + mrsp.result;
                                state_reg <= ST_TQ;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INT: begin
                    if (isum > trpid_pkg::INTEG_MAX) begin
                        integ_reg[axis_reg] <= trpid_pkg::INTEG_MAX[IW-1:0];
                        hit_reg             <= 1'b1;
                    end else if (isum < trpid_pkg::INTEG_MIN) begin
                        integ_reg[axis_reg] <= trpid_pkg::INTEG_MIN[IW-1:0];
                        hit_reg             <= 1'b1;
                    end else begin
                        integ_reg[axis_reg] <= isum[IW-1:0];
                    end
                    op_reg    <= OP_KP;
                    state_reg <= ST_ISSUE;
                end
                ST_TQ: begin
                    if (tneg > trpid_pkg::TQ_MAX) begin
                        tq_reg[axis_reg] <= trpid_pkg::TQ_MAX[TW-1:0];
                        hit_reg          <= 1'b1;
                    end else if (tneg < trpid_pkg::TQ_MIN) begin
                        tq_reg[axis_reg] <= trpid_pkg::TQ_MIN[TW-1:0];
                        hit_reg          <= 1'b1;
                    end else begin
                        tq_reg[axis_reg] <= tneg[TW-1:0];
                    end
                    prev_reg[axis_reg] <= r_cur;
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_DONE;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        op_reg    <= OP_DER;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= {tq_reg[2], tq_reg[1], tq_reg[0]};
                        m_user_reg  <= hit_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* sv/trpid_checker.sv */
// port-level checks for the three-axis rate pid core
`include "three_axis_rate_pid_core_macros.svh"

module trpid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    `TRPID_ASSERT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
    `TRPID_ASSERT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result too early")
    `TRPID_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `TRPID_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind three_axis_rate_pid_core trpid_checker u_trpid_checker (.*);
